>>> sv/dfhp_pkg.sv
`default_nettype none

package dfhp_pkg;

    // Header geometry and counter limit
    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned COUNT_W   = 33;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 33'h1_FFFF_FFFF;

    // Payload types that carry captured fields
    localparam logic [15:0] PT_ANNOUNCE   = 16'h0004;
    localparam logic [15:0] PT_ROUTE_REQ  = 16'h0005;
    localparam logic [15:0] PT_ROUTE_RESP = 16'h0006;
    localparam logic [15:0] PT_DIAG       = 16'h8001;
    localparam logic [15:0] PT_DIAG_ACK   = 16'h8002;
    localparam logic [15:0] PT_DIAG_NACK  = 16'h8003;

    localparam logic [7:0] VERSION_XOR  = 8'hFF;
    localparam logic [4:0] CLASS_UNKNOWN = 5'd16;
    localparam logic [31:0] SYNC_MIN_LEN = 32'd33;

    // Byte offsets inside the announcement payload
    localparam logic [COUNT_W-1:0] ANN_ADDR_HI = 33'd17;
    localparam logic [COUNT_W-1:0] ANN_ADDR_LO = 33'd18;
    localparam logic [COUNT_W-1:0] ANN_ACTION  = 33'd31;
    localparam logic [COUNT_W-1:0] ANN_SYNC    = 33'd32;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_SHORT       = 2'd1,
        ST_BAD_VERSION = 2'd2,
        ST_TRUNCATED   = 2'd3
    } t_status;

    // Frame state after the byte in flight has been taken
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         version;
        logic [7:0]         inv_version;
        logic [15:0]        ptype;
        logic [31:0]        length;
        logic [15:0]        addr_one;
        logic [15:0]        addr_two;
        logic [7:0]         code;
        logic [7:0]         sync;
    } t_frame_view;

    // Dense class of a payload type, in code order
    function automatic logic [4:0] type_class(input logic [15:0] t);
        logic [4:0] c;
        unique case (t)
            16'h0000: c = 5'd0;
            16'h0001: c = 5'd1;
            16'h0002: c = 5'd2;
            16'h0003: c = 5'd3;
            16'h0004: c = 5'd4;
            16'h0005: c = 5'd5;
            16'h0006: c = 5'd6;
            16'h0007: c = 5'd7;
            16'h0008: c = 5'd8;
            16'h4001: c = 5'd9;
            16'h4002: c = 5'd10;
            16'h4003: c = 5'd11;
            16'h4004: c = 5'd12;
            16'h8001: c = 5'd13;
            16'h8002: c = 5'd14;
            16'h8003: c = 5'd15;
            default:  c = CLASS_UNKNOWN;
        endcase
        return c;
    endfunction

    // Smallest payload that carries all fields of a type, the announcement's optional sync byte apart
    function automatic logic [5:0] min_payload(input logic [15:0] t);
        logic [5:0] m;
        unique case (t)
            PT_ANNOUNCE:   m = 6'd32;
            PT_ROUTE_REQ:  m = 6'd3;
            PT_ROUTE_RESP: m = 6'd5;
            PT_DIAG:       m = 6'd4;
            PT_DIAG_ACK:   m = 6'd5;
            PT_DIAG_NACK:  m = 6'd5;
            default:       m = 6'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/dfhp_frame_state.sv
`default_nettype none

module dfhp_frame_state (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    output dfhp_pkg::t_frame_view   o_view
);
    import dfhp_pkg::*;

    t_frame_view r_st;
    t_frame_view n_st;

    logic [COUNT_W-1:0] pos;
    logic               in_header;
    logic               in_payload;

    assign in_header  = (r_st.count < COUNT_W'(HDR_BYTES));
    assign pos        = r_st.count - COUNT_W'(HDR_BYTES);
    assign in_payload = !in_header && ({1'b0, pos} < {2'b0, r_st.length});

    // Capture the byte at its header or payload position
    always_comb begin
        n_st = r_st;
        if (in_header) begin
            unique case (r_st.count[2:0])
                3'd0: n_st.version       = i_byte;
                3'd1: n_st.inv_version   = i_byte;
                3'd2: n_st.ptype[15:8]   = i_byte;
                3'd3: n_st.ptype[7:0]    = i_byte;
                3'd4: n_st.length[31:24] = i_byte;
                3'd5: n_st.length[23:16] = i_byte;
                3'd6: n_st.length[15:8]  = i_byte;
                3'd7: n_st.length[7:0]   = i_byte;
                default: n_st.version    = r_st.version;
            endcase
        end else if (in_payload) begin
            priority case (r_st.ptype)
                PT_ANNOUNCE: begin
                    if (pos == ANN_ADDR_HI)      n_st.addr_one[15:8] = i_byte;
                    else if (pos == ANN_ADDR_LO) n_st.addr_one[7:0]  = i_byte;
                    else if (pos == ANN_ACTION)  n_st.code           = i_byte;
                    else if (pos == ANN_SYNC)    n_st.sync           = i_byte;
                end
                PT_ROUTE_REQ: begin
                    if (pos == 33'd0)      n_st.addr_one[15:8] = i_byte;
                    else if (pos == 33'd1) n_st.addr_one[7:0]  = i_byte;
                    else if (pos == 33'd2) n_st.code           = i_byte;
                end
                PT_ROUTE_RESP, PT_DIAG, PT_DIAG_ACK, PT_DIAG_NACK: begin
                    if (pos == 33'd0)      n_st.addr_one[15:8] = i_byte;
                    else if (pos == 33'd1) n_st.addr_one[7:0]  = i_byte;
                    else if (pos == 33'd2) n_st.addr_two[15:8] = i_byte;
                    else if (pos == 33'd3) n_st.addr_two[7:0]  = i_byte;
                    else if (pos == 33'd4 && r_st.ptype != PT_DIAG) n_st.code = i_byte;
                end
                default: n_st.code = r_st.code;
            endcase
        end
        // Saturate the byte counter
        if (r_st.count != COUNT_MAX) n_st.count = r_st.count + 1'b1;
    end

    assign o_view = n_st;

    // Advance per byte; clear after the verdict byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            if (i_last) r_st <= '0;
            else        r_st <= n_st;
        end
    end

endmodule

`default_nettype wire

>>> sv/doip_frame_header_parser.sv
// DoIP frame header parser.
// Input channel: one frame byte per transfer on i_data_byte, with i_last_byte
// marking the final byte of a frame. A transfer happens on a rising edge with
// i_in_valid high and o_in_stall low.
// Output channel: one verdict per frame, presented on o_out_valid with all
// result fields; it is taken on an edge with o_out_valid high and i_out_stall
// low.
// Throughput: one byte per cycle, sustained, frames back to back, while no
// stalled verdict holds a final byte back. Verdict path: the last byte sits
// in the input register, then the result register loads the verdict as that
// byte moves on. Header and field capture is a position compare plus a byte
// load between those two registers.
// Reset (i_rst_n low at a clock edge) empties both registers and clears the
// frame state; the next byte taken is byte 0 of a new frame.
// Receiver stall: a waiting verdict holds steady. Non-final bytes keep
// flowing into the frame state; a final byte waits in the input register, and
// o_in_stall rises while it cannot move on.
`default_nettype none

module doip_frame_header_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [7:0]       o_protocol_version,
    output logic [15:0]      o_payload_type,
    output logic [4:0]       o_type_class,
    output logic [31:0]      o_payload_length,
    output logic [15:0]      o_first_address,
    output logic [15:0]      o_second_address,
    output logic [7:0]       o_code_value,
    output logic [7:0]       o_sync_status,
    output logic             o_has_sync_status,
    output logic             o_fields_decoded
);
    import dfhp_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Result register
    logic        r_out_valid;
    t_status     r_status;
    logic [7:0]  r_version;
    logic [15:0] r_ptype;
    logic [4:0]  r_class;
    logic [31:0] r_length;
    logic [15:0] r_addr_one;
    logic [15:0] r_addr_two;
    logic [7:0]  r_code;
    logic [7:0]  r_sync;
    logic        r_has_sync;
    logic        r_decoded;

    t_frame_view view;
    logic        advance;
    logic        in_xfer;
    logic        out_free;

    t_status     n_status;
    logic        n_decoded;
    logic        n_fields;
    logic [5:0]  min_len;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    dfhp_frame_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_view  (view)
    );

    // Hold or refill the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Judge the frame from the state that includes the final byte
    assign min_len = min_payload(view.ptype);

    always_comb begin
        if (view.count < COUNT_W'(HDR_BYTES)) begin
            n_status = ST_SHORT;
        end else if ((view.version ^ view.inv_version) != VERSION_XOR) begin
            n_status = ST_BAD_VERSION;
        end else if ({1'b0, view.count} < ({2'b0, view.length} + 34'(HDR_BYTES))) begin
            n_status = ST_TRUNCATED;
        end else begin
            n_status = ST_OK;
        end
    end

    assign n_decoded = (n_status == ST_OK) && (view.length >= {26'd0, min_len});
    assign n_fields  = n_decoded && (min_len != 6'd0);

    // Load a verdict, or drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_status   <= n_status;
            r_version  <= (n_status != ST_SHORT) ? view.version : 8'd0;
            r_ptype    <= (n_status != ST_SHORT) ? view.ptype   : 16'd0;
            r_length   <= (n_status != ST_SHORT) ? view.length  : 32'd0;
            r_class    <= (n_status == ST_OK) ? type_class(view.ptype) : CLASS_UNKNOWN;
            r_addr_one <= n_fields ? view.addr_one : 16'd0;
            r_addr_two <= n_fields ? view.addr_two : 16'd0;
            r_code     <= n_fields ? view.code     : 8'd0;
            if (n_fields && view.ptype == PT_ANNOUNCE && view.length >= SYNC_MIN_LEN) begin
                r_sync     <= view.sync;
                r_has_sync <= 1'b1;
            end else begin
                r_sync     <= 8'd0;
                r_has_sync <= 1'b0;
            end
            r_decoded  <= n_decoded;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_protocol_version = r_version;
    assign o_payload_type     = r_ptype;
    assign o_type_class       = r_class;
    assign o_payload_length   = r_length;
    assign o_first_address    = r_addr_one;
    assign o_second_address   = r_addr_two;
    assign o_code_value       = r_code;
    assign o_sync_status      = r_sync;
    assign o_has_sync_status  = r_has_sync;
    assign o_fields_decoded   = r_decoded;

endmodule

`default_nettype wire

>>> sv/dfhp_checker.sv
`default_nettype none

module dfhp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic [7:0]  o_protocol_version,
    input wire logic [15:0] o_payload_type,
    input wire logic [4:0]  o_type_class,
    input wire logic [31:0] o_payload_length,
    input wire logic [15:0] o_first_address,
    input wire logic        o_has_sync_status,
    input wire logic        o_fields_decoded
);
    import dfhp_pkg::*;

    // A stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_payload_length) && $stable(o_first_address))
        else $error("verdict changed while stalled");

    // Short frame reports no header fields
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_SHORT |-> o_protocol_version == 8'd0
            && o_payload_type == 16'd0 && o_payload_length == 32'd0)
        else $error("short frame carries header fields");

    // Failed frame is unclassified and undecoded
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_type_class == CLASS_UNKNOWN
            && !o_fields_decoded && o_first_address == 16'd0)
        else $error("failed frame reports fields");

    // Sync status only for a decoded long announcement
    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_sync_status |-> o_fields_decoded
            && o_payload_type == PT_ANNOUNCE && o_payload_length >= SYNC_MIN_LEN)
        else $error("sync status on wrong frame");

endmodule

bind doip_frame_header_parser dfhp_checker u_dfhp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_status           (o_status),
    .o_protocol_version (o_protocol_version),
    .o_payload_type     (o_payload_type),
    .o_type_class       (o_type_class),
    .o_payload_length   (o_payload_length),
    .o_first_address    (o_first_address),
    .o_has_sync_status  (o_has_sync_status),
    .o_fields_decoded   (o_fields_decoded)
);

`default_nettype wire

>>> verif/doip_frame_header_parser_checker.sv
`default_nettype none

module doip_frame_header_parser_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [7:0]  i_protocol_version,
    input  wire logic [15:0] i_payload_type,
    input  wire logic [4:0]  i_type_class,
    input  wire logic [31:0] i_payload_length,
    input  wire logic [15:0] i_first_address,
    input  wire logic [15:0] i_second_address,
    input  wire logic [7:0]  i_code_value,
    input  wire logic [7:0]  i_sync_status,
    input  wire logic        i_has_sync_status,
    input  wire logic        i_fields_decoded,
    output int               o_fail_count,
    output int               o_pending
);
    import dfhp_pkg::*;

    // Known type ranges outside the field-carrying diagnostic group
    localparam logic [15:0] GENERIC_TYPE_LAST = 16'h0008;
    localparam logic [15:0] NODE_TYPE_FIRST   = 16'h4001;
    localparam logic [15:0] NODE_TYPE_LAST    = 16'h4004;

    typedef struct packed {
        t_status     status;
        logic [7:0]  version;
        logic [15:0] ptype;
        logic [4:0]  tclass;
        logic [31:0] length;
        logic [15:0] addr_one;
        logic [15:0] addr_two;
        logic [7:0]  code;
        logic [7:0]  sync;
        logic        has_sync;
        logic        decoded;
    } t_verdict;

    t_verdict verdict_q[$];
    int       mismatches = 0;

    // Shadow of the frame being parsed
    logic [COUNT_W-1:0] frm_count;
    logic [7:0]         frm_version;
    logic [7:0]         frm_inv;
    logic [15:0]        frm_type;
    logic [31:0]        frm_length;
    logic [15:0]        frm_addr_one;
    logic [15:0]        frm_addr_two;
    logic [7:0]         frm_code;
    logic [7:0]         frm_sync;

    function automatic logic [4:0] class_of(input logic [15:0] t);
        logic [4:0] c;
        if (t <= GENERIC_TYPE_LAST) begin
            c = t[4:0];
        end else if (t >= NODE_TYPE_FIRST && t <= NODE_TYPE_LAST) begin
            c = 5'd8 + t[4:0];
        end else if (t >= PT_DIAG && t <= PT_DIAG_NACK) begin
            c = 5'd12 + t[4:0];
        end else begin
            c = CLASS_UNKNOWN;
        end
        return c;
    endfunction

    function automatic int unsigned min_fields(input logic [15:0] t);
        case (t)
            PT_ANNOUNCE:   return 32;
            PT_ROUTE_REQ:  return 3;
            PT_ROUTE_RESP: return 5;
            PT_DIAG:       return 4;
            PT_DIAG_ACK:   return 5;
            PT_DIAG_NACK:  return 5;
            default:       return 0;
        endcase
    endfunction

    task automatic clear_frame();
        frm_count    = '0;
        frm_version  = '0;
        frm_inv      = '0;
        frm_type     = '0;
        frm_length   = '0;
        frm_addr_one = '0;
        frm_addr_two = '0;
        frm_code     = '0;
        frm_sync     = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // Pick up type-specific fields from a byte inside the declared payload
    task automatic capture_payload(input logic [COUNT_W-1:0] pos, input logic [7:0] b);
        case (frm_type)
            PT_ANNOUNCE: begin
                if (pos == ANN_ADDR_HI)      frm_addr_one[15:8] = b;
                else if (pos == ANN_ADDR_LO) frm_addr_one[7:0]  = b;
                else if (pos == ANN_ACTION)  frm_code           = b;
                else if (pos == ANN_SYNC)    frm_sync           = b;
            end
            PT_ROUTE_REQ: begin
                if (pos == 0)      frm_addr_one[15:8] = b;
                else if (pos == 1) frm_addr_one[7:0]  = b;
                else if (pos == 2) frm_code           = b;
            end
            PT_ROUTE_RESP, PT_DIAG, PT_DIAG_ACK, PT_DIAG_NACK: begin
                if (pos == 0)      frm_addr_one[15:8] = b;
                else if (pos == 1) frm_addr_one[7:0]  = b;
                else if (pos == 2) frm_addr_two[15:8] = b;
                else if (pos == 3) frm_addr_two[7:0]  = b;
                else if (pos == 4 && frm_type != PT_DIAG) frm_code = b;
            end
            default: ;
        endcase
    endtask

    // Advance the frame shadow by one byte; on the last byte queue the verdict
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        logic [COUNT_W-1:0] pos;
        logic [COUNT_W:0]   needed;
        int unsigned        floor_len;
        t_verdict           v;
        pos = frm_count - COUNT_W'(HDR_BYTES);
        if (frm_count < COUNT_W'(HDR_BYTES)) begin
            case (frm_count[2:0])
                3'd0:    frm_version        = b;
                3'd1:    frm_inv            = b;
                3'd2:    frm_type[15:8]     = b;
                3'd3:    frm_type[7:0]      = b;
                3'd4:    frm_length[31:24]  = b;
                3'd5:    frm_length[23:16]  = b;
                3'd6:    frm_length[15:8]   = b;
                default: frm_length[7:0]    = b;
            endcase
        end else if (pos < {1'b0, frm_length}) begin
            capture_payload(pos, b);
        end
        if (frm_count != COUNT_MAX)
            frm_count++;
        if (!last)
            return;

        v = '0;
        v.tclass = CLASS_UNKNOWN;
        needed = (COUNT_W+1)'(HDR_BYTES) + (COUNT_W+1)'(frm_length);
        if (frm_count < COUNT_W'(HDR_BYTES))
            v.status = ST_SHORT;
        else if ((frm_version ^ frm_inv) != VERSION_XOR)
            v.status = ST_BAD_VERSION;
        else if ({1'b0, frm_count} < needed)
            v.status = ST_TRUNCATED;
        else
            v.status = ST_OK;

        if (v.status != ST_SHORT) begin
            v.version = frm_version;
            v.ptype   = frm_type;
            v.length  = frm_length;
        end
        if (v.status == ST_OK) begin
            floor_len = min_fields(frm_type);
            v.tclass  = class_of(frm_type);
            v.decoded = (frm_length >= floor_len);
            // Types without fields decode with all fields left at zero
            if (v.decoded && floor_len != 0) begin
                v.addr_one = frm_addr_one;
                v.addr_two = frm_addr_two;
                v.code     = frm_code;
                if (frm_type == PT_ANNOUNCE && frm_length >= SYNC_MIN_LEN) begin
                    v.sync     = frm_sync;
                    v.has_sync = 1'b1;
                end
            end
        end
        verdict_q.push_back(v);
        clear_frame();
    endtask

    task automatic check_verdict();
        t_verdict want;
        if (verdict_q.size() == 0) begin
            report_mismatch("verdict with no frame pending", 32'(i_status), 0);
            return;
        end
        want = verdict_q.pop_front();
        if (i_status != want.status)
            report_mismatch("status", 32'(i_status), 32'(want.status));
        if (i_protocol_version != want.version)
            report_mismatch("protocol_version", 32'(i_protocol_version), 32'(want.version));
        if (i_payload_type != want.ptype)
            report_mismatch("payload_type", 32'(i_payload_type), 32'(want.ptype));
        if (i_type_class != want.tclass)
            report_mismatch("type_class", 32'(i_type_class), 32'(want.tclass));
        if (i_payload_length != want.length)
            report_mismatch("payload_length", i_payload_length, want.length);
        if (i_first_address != want.addr_one)
            report_mismatch("first_address", 32'(i_first_address), 32'(want.addr_one));
        if (i_second_address != want.addr_two)
            report_mismatch("second_address", 32'(i_second_address), 32'(want.addr_two));
        if (i_code_value != want.code)
            report_mismatch("code_value", 32'(i_code_value), 32'(want.code));
        if (i_sync_status != want.sync)
            report_mismatch("sync_status", 32'(i_sync_status), 32'(want.sync));
        if (i_has_sync_status != want.has_sync)
            report_mismatch("has_sync_status", 32'(i_has_sync_status), 32'(want.has_sync));
        if (i_fields_decoded != want.decoded)
            report_mismatch("fields_decoded", 32'(i_fields_decoded), 32'(want.decoded));
    endtask

    // Watch both channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            verdict_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_verdict();
            if (i_in_valid && !i_in_stall)
                absorb_byte(i_data_byte, i_last_byte);
        end
        o_fail_count <= mismatches;
        o_pending    <= verdict_q.size();
    end

endmodule

`default_nettype wire

>>> verif/doip_frame_header_parser_tb.sv
`default_nettype none

module doip_frame_header_parser_tb;
    import dfhp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 325;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_protocol_version;
    logic [15:0] o_payload_type;
    logic [4:0]  o_type_class;
    logic [31:0] o_payload_length;
    logic [15:0] o_first_address;
    logic [15:0] o_second_address;
    logic [7:0]  o_code_value;
    logic [7:0]  o_sync_status;
    logic        o_has_sync_status;
    logic        o_fields_decoded;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          phase_bytes = 0;
    logic [7:0]  frame_q[$];

    doip_frame_header_parser DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_protocol_version (o_protocol_version),
        .o_payload_type     (o_payload_type),
        .o_type_class       (o_type_class),
        .o_payload_length   (o_payload_length),
        .o_first_address    (o_first_address),
        .o_second_address   (o_second_address),
        .o_code_value       (o_code_value),
        .o_sync_status      (o_sync_status),
        .o_has_sync_status  (o_has_sync_status),
        .o_fields_decoded   (o_fields_decoded)
    );

    doip_frame_header_parser_checker u_verdict_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_status           (o_status),
        .i_protocol_version (o_protocol_version),
        .i_payload_type     (o_payload_type),
        .i_type_class       (o_type_class),
        .i_payload_length   (o_payload_length),
        .i_first_address    (o_first_address),
        .i_second_address   (o_second_address),
        .i_code_value       (o_code_value),
        .i_sync_status      (o_sync_status),
        .i_has_sync_status  (o_has_sync_status),
        .i_fields_decoded   (o_fields_decoded),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("doip_frame_header_parser test failed");
            $finish;
        end
    end

    // Randomly hold off verdicts
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offer one byte, idling first at random; hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        phase_bytes++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    task automatic push_header(input logic [7:0] ver, input logic [7:0] inv,
                               input logic [15:0] ptype, input logic [31:0] len);
        frame_q.push_back(ver);
        frame_q.push_back(inv);
        frame_q.push_back(ptype[15:8]);
        frame_q.push_back(ptype[7:0]);
        frame_q.push_back(len[31:24]);
        frame_q.push_back(len[23:16]);
        frame_q.push_back(len[15:8]);
        frame_q.push_back(len[7:0]);
    endtask

    // Mostly field-carrying types, plus neighbors of the known code ranges
    function automatic logic [15:0] pick_type();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) begin
            case ($urandom_range(5))
                0:       return PT_ANNOUNCE;
                1:       return PT_ROUTE_REQ;
                2:       return PT_ROUTE_RESP;
                3:       return PT_DIAG;
                4:       return PT_DIAG_ACK;
                default: return PT_DIAG_NACK;
            endcase
        end
        if (r < 70)
            return {8'h00, 8'($urandom_range(9))};
        if (r < 80)
            return {8'h40, 8'($urandom_range(5))};
        if (r < 85)
            return {8'h80, 8'($urandom_range(4))};
        return 16'($urandom_range(65535));
    endfunction

    // Lengths around each type's field minimum
    function automatic logic [31:0] pick_length(input logic [15:0] ptype);
        if (ptype == PT_ANNOUNCE)
            return ($urandom_range(2) != 0) ? 32'(30 + $urandom_range(5))
                                            : 32'($urandom_range(35));
        return 32'($urandom_range(7));
    endfunction

    task automatic build_frame();
        logic [7:0]  ver;
        logic [7:0]  inv;
        logic [15:0] ptype;
        logic [31:0] len;
        int unsigned kind;
        int unsigned body;
        int unsigned extra;
        kind  = $urandom_range(99);
        ver   = 8'($urandom_range(255));
        inv   = ~ver;
        ptype = pick_type();
        len   = pick_length(ptype);
        body  = len;
        extra = ($urandom_range(2) == 0) ? $urandom_range(3) : 0;
        if (kind < 10) begin
            // shorter than a header
            repeat ($urandom_range(7, 1))
                frame_q.push_back(8'($urandom_range(255)));
            return;
        end
        if (kind < 20) begin
            // broken version pattern
            inv   = ~ver ^ 8'($urandom_range(255, 1));
            body  = $urandom_range(6);
            extra = 0;
            if ($urandom_range(1) != 0)
                len = $urandom();
        end else if (kind < 35) begin
            // declared payload longer than the frame
            if ($urandom_range(1) != 0)
                len = $urandom();
            if (len == 0)
                len = 32'($urandom_range(40, 1));
            body  = (len > 8) ? $urandom_range(8) : $urandom_range(len - 1);
            extra = 0;
        end
        push_header(ver, inv, ptype, len);
        repeat (body + extra)
            frame_q.push_back(8'($urandom_range(255)));
    endtask

    initial begin
        int idle_mix[4][2];
        idle_mix = '{'{0, 0}, '{71, 0}, '{0, 71}, '{19, 19}};
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-byte frame, short frame of zeros
        frame_q.push_back(8'hFF);
        send_frame();
        repeat (5) frame_q.push_back(8'h00);
        send_frame();
        // Header only, version equals inverse, all-ones type and length
        push_header(8'h02, 8'h02, 16'hFFFF, 32'hFFFF_FFFF);
        send_frame();
        // Routing request at exactly its minimum payload
        push_header(8'h02, 8'hFD, PT_ROUTE_REQ, 32'd3);
        frame_q.push_back(8'h0E);
        frame_q.push_back(8'h80);
        frame_q.push_back(8'h01);
        send_frame();

        // Random frames under each idle mix
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_mix[p][0];
            stall_pct     = idle_mix[p][1];
            phase_bytes   = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_frame();
                send_frame();
            end
        end

        // Drain outstanding verdicts
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("doip_frame_header_parser test passed");
        else
            $display("doip_frame_header_parser test failed");
        $finish;
    end

endmodule

`default_nettype wire
